### src/wrs_pkg.sv
// Shared types, constants and helpers of the warp register scoreboard.
`default_nettype none
package wrs_pkg;

  localparam int unsigned WRS_WARPS      = 64;
  localparam int unsigned WRS_REGS       = 256;
  localparam int unsigned WRS_REG_FIELDS = 4;
  localparam int unsigned WRS_NFIELDS    = 4;
  localparam int unsigned CNT_W          = 9;

  typedef enum logic [2:0] {
    CMD_RESERVE = 3'd0,
    CMD_RELEASE = 3'd1,
    CMD_READY   = 3'd2,
    CMD_CHECK   = 3'd3,
    CMD_QUERY   = 3'd4
  } cmd_e;

  // Producer classes, ordered by severity.
  localparam logic [2:0] CLS_OTHER  = 3'd0;
  localparam logic [2:0] CLS_ALU    = 3'd1;
  localparam logic [2:0] CLS_SHMEM  = 3'd2;
  localparam logic [2:0] CLS_SFU    = 3'd3;
  localparam logic [2:0] CLS_TENSOR = 3'd4;
  localparam logic [2:0] CLS_TMA    = 3'd5;
  localparam logic [2:0] CLS_GLOBAL = 3'd6;

  typedef enum logic [4:0] {
    ST_CLR  = 5'b00001,
    ST_IDLE = 5'b00010,
    ST_LDC  = 5'b00100,
    ST_RD   = 5'b01000,
    ST_MOD  = 5'b10000
  } state_e;

  typedef struct packed {
    logic        rsv;
    logic        rdy;
    logic        lng;
    logic [31:0] owner;
    logic [2:0]  kind;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  function automatic logic [2:0] severity_of(logic [2:0] cls);
    severity_of = (cls <= CLS_GLOBAL) ? cls : CLS_OTHER;
  endfunction

endpackage
`default_nettype wire

### src/wrs_if.sv
// Input and result channels of the warp register scoreboard.
`default_nettype none
interface wrs_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [5:0]  warp;
  logic [7:0]  reg_a;
  logic [7:0]  reg_b;
  logic [7:0]  reg_c;
  logic [7:0]  reg_d;
  logic [31:0] uid;
  logic [2:0]  producer_class;
  logic        long_load;
  logic        chain;
  modport source (output valid, cmd, warp, reg_a, reg_b, reg_c, reg_d, uid,
                  producer_class, long_load, chain, input ready);
  modport sink (input valid, cmd, warp, reg_a, reg_b, reg_c, reg_d, uid,
                producer_class, long_load, chain, output ready);
endinterface

interface wrs_out_if;
  logic       valid;
  logic       ready;
  logic       hazard;
  logic [2:0] worst_producer;
  logic       pending_writes;
  logic       long_op;
  logic       reserve_error;
  modport source (output valid, hazard, worst_producer, pending_writes, long_op,
                  reserve_error, input ready);
  modport sink (input valid, hazard, worst_producer, pending_writes, long_op,
                reserve_error, output ready);
endinterface
`default_nettype wire

### src/wrs_mem.sv
// Single-port synchronous RAM with registered read data.
`default_nettype none
module wrs_mem #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  output logic      [WIDTH-1:0]                 rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

### src/warp_register_scoreboard.sv
// Warp register scoreboard: per-warp register table in RAM with a field sequencer.
// Each item passes ST_LDC, then ST_RD reads the table entry of each field in turn; a field
// that touches the table (query touches only reg_a) goes on to ST_MOD, which writes back for
// reserve, release and ready; a used reg_d is followed by a final ST_RD. One item at a time:
// the next is accepted at the earliest as the result turns valid; a held result stalls the finish.
// Reset: sweep all WARPS*REGS table entries (16384) with ready low; accumulator clears.
`default_nettype none
module warp_register_scoreboard #(
  parameter int unsigned WARPS      = wrs_pkg::WRS_WARPS,
  parameter int unsigned REGS       = wrs_pkg::WRS_REGS,
  parameter int unsigned REG_FIELDS = wrs_pkg::WRS_REG_FIELDS
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  wrs_in_if.sink    in_i,
  wrs_out_if.source out_o
);
  import wrs_pkg::*;

  localparam int unsigned DEPTH = WARPS * REGS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned WW    = (WARPS > 1) ? $clog2(WARPS) : 1;
  localparam int unsigned NF    = (REG_FIELDS < WRS_NFIELDS) ? REG_FIELDS : WRS_NFIELDS;

  state_e           st_q, st_d;
  logic [AW-1:0]    clr_q;
  logic [2:0]       idx_q;
  logic [2:0]       cmd_q;
  logic [5:0]       warp_q;
  logic [7:0]       reg_q [WRS_NFIELDS];
  logic [31:0]      uid_q;
  logic [2:0]       pcls_q;
  logic             lng_q;
  logic             chain_q;
  logic [CNT_W-1:0] cnt_q;
  logic             acc_h_q, rerr_q, lop_q;
  logic [2:0]       acc_w_q;
  logic [3:0]       accum_q;
  logic             out_valid_q;
  logic             o_haz_q, o_pend_q, o_lop_q, o_rerr_q;
  logic [2:0]       o_worst_q;

  logic [7:0]       rv [WRS_NFIELDS];
  logic [7:0]       rv_cur;
  logic             wok, dup, use_cur, last_field, done_fin, out_free;
  logic             past_end, fields_done;
  logic [WW-1:0]    wix_q;
  logic [AW-1:0]    cur_addr;

  logic             tab_we;
  logic [AW-1:0]    tab_addr;
  entry_t           tab_wdata, tab_rdata, e_new;
  logic [ENTRY_W-1:0] tab_rraw;
  logic             cnt_we;
  logic [WW-1:0]    cnt_addr;
  logic [CNT_W-1:0] cnt_wdata, cnt_rdata;
  logic             blocking, owner_hit;

  // Usable register numbers: fields past REG_FIELDS or out of range read as unused.
  always_comb begin
    for (int i = 0; i < WRS_NFIELDS; i++) begin
      rv[i] = ((i < NF) && (11'(reg_q[i]) < 11'(REGS))) ? reg_q[i] : 8'd0;
    end
  end

  assign wix_q  = WW'(warp_q);
  assign wok    = 9'(warp_q) < 9'(WARPS);
  assign rv_cur = rv[idx_q[1:0]];
  assign cur_addr = AW'(wix_q) * AW'(REGS) + AW'(rv_cur);
  assign last_field = (idx_q == 3'(WRS_NFIELDS - 1));
  assign past_end   = (idx_q == 3'(WRS_NFIELDS));

  always_comb begin
    dup = 1'b0;
    for (int j = 0; j < WRS_NFIELDS; j++) begin
      if ((3'(j) < idx_q) && (rv[j] == rv_cur)) begin
        dup = 1'b1;
      end
    end
  end

  always_comb begin
    use_cur = 1'b0;
    if (wok && !past_end && (rv_cur != 8'd0)) begin
      case (cmd_q)
        CMD_RESERVE: use_cur = !dup;
        CMD_RELEASE: use_cur = 1'b1;
        CMD_READY:   use_cur = 1'b1;
        CMD_CHECK:   use_cur = 1'b1;
        CMD_QUERY:   use_cur = (idx_q == 3'd0);
        default:     use_cur = 1'b0;
      endcase
    end
  end

  assign tab_rdata = entry_t'(tab_rraw);
  assign blocking  = tab_rdata.rsv && !tab_rdata.rdy;
  assign owner_hit = tab_rdata.rsv && (tab_rdata.owner == uid_q);

  // Read-modify-write of one table entry.
  always_comb begin
    e_new  = tab_rdata;
    tab_we = 1'b0;
    case (cmd_q)
      CMD_RESERVE: begin
        if (!blocking) begin
          tab_we      = 1'b1;
          e_new.rsv   = 1'b1;
          e_new.rdy   = 1'b0;
          e_new.lng   = tab_rdata.lng | lng_q;
          e_new.owner = uid_q;
          e_new.kind  = pcls_q;
        end
      end
      CMD_RELEASE: begin
        if (owner_hit) begin
          tab_we    = 1'b1;
          e_new.rsv = 1'b0;
          e_new.rdy = 1'b0;
          e_new.lng = 1'b0;
        end
      end
      CMD_READY: begin
        if (owner_hit) begin
          tab_we    = 1'b1;
          e_new.rdy = 1'b1;
        end
      end
      default: tab_we = 1'b0;
    endcase
  end

  assign out_free    = !out_valid_q || out_o.ready;
  assign fields_done = past_end || (last_field && !use_cur);
  assign done_fin    = (st_q == ST_RD) && fields_done && out_free;

  always_comb begin
    tab_addr  = cur_addr;
    tab_wdata = e_new;
    if (st_q == ST_CLR) begin
      tab_addr  = clr_q;
      tab_wdata = '0;
    end
  end

  always_comb begin
    cnt_we    = 1'b0;
    cnt_addr  = wix_q;
    cnt_wdata = cnt_q;
    case (st_q)
      ST_CLR: begin
        cnt_we    = (int'(clr_q) < WARPS);
        cnt_addr  = WW'(clr_q);
        cnt_wdata = '0;
      end
      ST_IDLE: cnt_addr = WW'(in_i.warp);
      ST_RD: cnt_we = done_fin && wok &&
                      (cmd_q == CMD_RESERVE || cmd_q == CMD_RELEASE);
      default: cnt_we = 1'b0;
    endcase
  end

  wrs_mem #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_tab (
    .clk_i   (clk_i),
    .we_i    ((st_q == ST_CLR) || ((st_q == ST_MOD) && tab_we)),
    .addr_i  (tab_addr),
    .wdata_i (tab_wdata),
    .rdata_o (tab_rraw)
  );

  wrs_mem #(.WIDTH(CNT_W), .DEPTH(WARPS)) u_cnt (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .addr_i  (cnt_addr),
    .wdata_i (cnt_wdata),
    .rdata_o (cnt_rdata)
  );

  assign in_i.ready = (st_q == ST_IDLE);

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_CLR:  if (clr_q == AW'(DEPTH - 1)) st_d = ST_IDLE;
      ST_IDLE: if (in_i.valid) st_d = ST_LDC;
      ST_LDC:  st_d = ST_RD;
      ST_RD: begin
        if (use_cur) st_d = ST_MOD;
        else if (done_fin) st_d = ST_IDLE;
      end
      ST_MOD:  st_d = ST_RD;
      default: st_d = ST_CLR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_CLR;
      clr_q       <= '0;
      accum_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == ST_CLR) clr_q <= clr_q + AW'(1);
      if (done_fin) begin
        out_valid_q <= 1'b1;
        if (cmd_q == CMD_CHECK) accum_q <= {acc_h_q, acc_w_q};
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        cmd_q    <= in_i.cmd;
        warp_q   <= in_i.warp;
        reg_q[0] <= in_i.reg_a;
        reg_q[1] <= in_i.reg_b;
        reg_q[2] <= in_i.reg_c;
        reg_q[3] <= in_i.reg_d;
        uid_q    <= in_i.uid;
        pcls_q   <= in_i.producer_class;
        lng_q    <= in_i.long_load;
        chain_q  <= in_i.chain;
      end
      ST_LDC: begin
        idx_q   <= '0;
        cnt_q   <= cnt_rdata;
        rerr_q  <= 1'b0;
        lop_q   <= 1'b0;
        acc_h_q <= chain_q ? accum_q[3] : 1'b0;
        acc_w_q <= chain_q ? accum_q[2:0] : 3'd0;
      end
      ST_RD: begin
        if (!use_cur && !fields_done) idx_q <= idx_q + 3'd1;
        if (done_fin) begin
          o_haz_q   <= (cmd_q == CMD_CHECK) && acc_h_q;
          o_worst_q <= (cmd_q == CMD_CHECK) ? acc_w_q : 3'd0;
          o_pend_q  <= (cmd_q == CMD_QUERY) && wok && (cnt_q != '0);
          o_lop_q   <= (cmd_q == CMD_QUERY) && lop_q;
          o_rerr_q  <= (cmd_q == CMD_RESERVE) && rerr_q;
        end
      end
      ST_MOD: begin
        // A last field that was used is never used again: step past it.
        if (last_field) idx_q <= 3'(WRS_NFIELDS);
        else idx_q <= idx_q + 3'd1;
        case (cmd_q)
          CMD_RESERVE: begin
            if (blocking) rerr_q <= 1'b1;
            else if (!tab_rdata.rsv) cnt_q <= cnt_q + CNT_W'(1);
          end
          CMD_RELEASE: begin
            if (owner_hit && (cnt_q != '0)) cnt_q <= cnt_q - CNT_W'(1);
          end
          CMD_CHECK: begin
            if (blocking) begin
              acc_h_q <= 1'b1;
              if (severity_of(tab_rdata.kind) > acc_w_q) begin
                acc_w_q <= severity_of(tab_rdata.kind);
              end
            end
          end
          CMD_QUERY: lop_q <= tab_rdata.lng;
          default: lop_q <= lop_q;
        endcase
      end
      default: idx_q <= idx_q;
    endcase
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.hazard         = o_haz_q;
  assign out_o.worst_producer = o_worst_q;
  assign out_o.pending_writes = o_pend_q;
  assign out_o.long_op        = o_lop_q;
  assign out_o.reserve_error  = o_rerr_q;

  // Count writes happen only during the clearing sweep or at an item's finish.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_RD || st_q == ST_IDLE || st_q == ST_LDC) |-> !cnt_we || st_q == ST_RD)
    else $error("count written outside sweep or finish");

  // A finished item always lands in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_fin |=> out_valid_q)
    else $error("result lost at finish");

  // No item is accepted while the sweep runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_CLR) |-> !in_i.ready)
    else $error("input ready during clearing sweep");

endmodule
`default_nettype wire

### sim/wrs_checker.sv
// Scoreboard checker: watches both channels, predicts each result and compares it.
`timescale 1ns / 1ps
`default_nettype none
module wrs_checker
  import wrs_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  wrs_in_if         in_mon,
  wrs_out_if        out_mon,
  output int        fails_o,
  output int        outstanding_o
);

  typedef struct packed {
    logic       hazard;
    logic [2:0] worst;
    logic       pend;
    logic       lop;
    logic       rerr;
  } verdict_t;

  logic        rsv_m [WRS_WARPS][WRS_REGS];
  logic        rdy_m [WRS_WARPS][WRS_REGS];
  logic        lng_m [WRS_WARPS][WRS_REGS];
  logic [31:0] owner_m [WRS_WARPS][WRS_REGS];
  logic [2:0]  kind_m [WRS_WARPS][WRS_REGS];
  logic [8:0]  busy_cnt [WRS_WARPS];
  logic        acc_hz;
  logic [2:0]  acc_worst;

  verdict_t expected_q[$];

  assign outstanding_o = expected_q.size();

  task automatic check_field(input string name, input logic [2:0] exp_v,
                             input logic [2:0] act_v);
    if (exp_v !== act_v) begin
      fails_o++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v, act_v);
    end
  endtask

  // Update the shadow table for one accepted beat and queue its outcome.
  task automatic scoreboard_beat();
    logic [7:0] r [4];
    logic [5:0] w;
    logic       dup;
    logic [2:0] sev;
    verdict_t   v;
    v = '0;
    w = in_mon.warp;
    r[0] = in_mon.reg_a;
    r[1] = in_mon.reg_b;
    r[2] = in_mon.reg_c;
    r[3] = in_mon.reg_d;
    case (in_mon.cmd)
      CMD_CHECK: begin
        if (!in_mon.chain) begin
          acc_hz = 1'b0;
          acc_worst = CLS_OTHER;
        end
        for (int i = 0; i < 4; i++) begin
          if (r[i] != 0 && rsv_m[w][r[i]] && !rdy_m[w][r[i]]) begin
            sev = (kind_m[w][r[i]] > CLS_GLOBAL) ? CLS_OTHER : kind_m[w][r[i]];
            acc_hz = 1'b1;
            if (sev > acc_worst) acc_worst = sev;
          end
        end
        v.hazard = acc_hz;
        v.worst = acc_worst;
      end
      CMD_RESERVE: begin
        for (int i = 0; i < 4; i++) begin
          dup = 1'b0;
          for (int j = 0; j < i; j++) if (r[j] == r[i]) dup = 1'b1;
          if (r[i] == 0 || dup) continue;
          if (rsv_m[w][r[i]] && !rdy_m[w][r[i]]) begin
            v.rerr = 1'b1;
            continue;
          end
          if (!rsv_m[w][r[i]]) busy_cnt[w]++;
          rsv_m[w][r[i]] = 1'b1;
          rdy_m[w][r[i]] = 1'b0;
          owner_m[w][r[i]] = in_mon.uid;
          kind_m[w][r[i]] = in_mon.producer_class;
          if (in_mon.long_load) lng_m[w][r[i]] = 1'b1;
        end
      end
      CMD_RELEASE, CMD_READY: begin
        for (int i = 0; i < 4; i++) begin
          if (r[i] == 0 || !rsv_m[w][r[i]] || owner_m[w][r[i]] != in_mon.uid) continue;
          if (in_mon.cmd == CMD_READY) begin
            rdy_m[w][r[i]] = 1'b1;
          end else begin
            rsv_m[w][r[i]] = 1'b0;
            rdy_m[w][r[i]] = 1'b0;
            lng_m[w][r[i]] = 1'b0;
            if (busy_cnt[w] != 0) busy_cnt[w]--;
          end
        end
      end
      CMD_QUERY: begin
        v.pend = (busy_cnt[w] != 0);
        if (r[0] != 0) v.lop = lng_m[w][r[0]];
      end
      default: ;
    endcase
    expected_q.push_back(v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t e;
    if (!rst_ni) begin
      for (int w = 0; w < WRS_WARPS; w++) begin
        busy_cnt[w] = '0;
        for (int g = 0; g < WRS_REGS; g++) begin
          rsv_m[w][g] = 1'b0;
          rdy_m[w][g] = 1'b0;
          lng_m[w][g] = 1'b0;
        end
      end
      acc_hz = 1'b0;
      acc_worst = CLS_OTHER;
      expected_q.delete();
      fails_o = 0;
    end else begin
      // Compare first so a result never meets the expectation of the beat it overlaps.
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          fails_o++;
          $display("%0t: result beat with nothing expected, actual %b", $realtime,
                   {out_mon.hazard, out_mon.worst_producer, out_mon.pending_writes,
                    out_mon.long_op, out_mon.reserve_error});
        end else begin
          e = expected_q.pop_front();
          check_field("hazard", 3'(e.hazard), 3'(out_mon.hazard));
          check_field("worst_producer", e.worst, out_mon.worst_producer);
          check_field("pending_writes", 3'(e.pend), 3'(out_mon.pending_writes));
          check_field("long_op", 3'(e.lop), 3'(out_mon.long_op));
          check_field("reserve_error", 3'(e.rerr), 3'(out_mon.reserve_error));
        end
      end
      if (in_mon.valid && in_mon.ready) scoreboard_beat();
    end
  end

endmodule
`default_nettype wire

### sim/tb.sv
// Testbench top: clock, reset, stimulus, stall control and verdict for the scoreboard.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import wrs_pkg::*;

  localparam int WATCHDOG_LIMIT = 60000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fails;
  int   outstanding;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  bit   hold_req = 1'b0;
  int   quiet_cycles = 0;
  logic [31:0] uid_pool [4] = '{32'h1, 32'h2, 32'hFFFF_FFFF, 32'h0};

  wrs_in_if  in_ch();
  wrs_out_if out_ch();

  warp_register_scoreboard DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  wrs_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fails_o       (fails),
    .outstanding_o (outstanding)
  );

  always #4 clk_i = ~clk_i;

  // Receiver: random stalls, or a long hold-off on request.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send(input logic [2:0] c, input logic [5:0] w, input logic [7:0] a,
                      input logic [7:0] b, input logic [7:0] cc, input logic [7:0] d,
                      input logic [31:0] u, input logic [2:0] cls, input logic lng,
                      input logic chn);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= c;
    in_ch.warp <= w;
    in_ch.reg_a <= a;
    in_ch.reg_b <= b;
    in_ch.reg_c <= cc;
    in_ch.reg_d <= d;
    in_ch.uid <= u;
    in_ch.producer_class <= cls;
    in_ch.long_load <= lng;
    in_ch.chain <= chn;
    @(posedge clk_i iff in_ch.ready);
  endtask

  function automatic logic [7:0] pick_reg();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 8'($urandom_range(6, 1));
    if (r < 80) return 8'd0;
    if (r < 90) return 8'($urandom_range(255, 254));
    return 8'($urandom);
  endfunction

  task automatic send_random();
    logic [2:0]  c;
    logic [5:0]  w;
    logic [31:0] u;
    int r;
    r = $urandom_range(99);
    if (r < 30) c = CMD_RESERVE;
    else if (r < 45) c = CMD_RELEASE;
    else if (r < 62) c = CMD_READY;
    else if (r < 82) c = CMD_CHECK;
    else if (r < 95) c = CMD_QUERY;
    else c = 3'($urandom_range(7, 5));
    r = $urandom_range(9);
    w = (r < 5) ? 6'd0 : (r < 7) ? 6'd63 : (r < 9) ? 6'd1 : 6'($urandom);
    u = ($urandom_range(4) == 0) ? $urandom : uid_pool[$urandom_range(3)];
    // Rotate fresh ids into the pool so owner matches keep happening.
    if (c == CMD_RESERVE && $urandom_range(2) == 0) begin
      u = $urandom;
      uid_pool[$urandom_range(3)] = u;
    end
    send(c, w, pick_reg(), pick_reg(), pick_reg(), pick_reg(), u,
         3'($urandom_range(7)), 1'($urandom), 1'($urandom));
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.cmd <= CMD_QUERY;
    in_ch.warp <= '0;
    in_ch.reg_a <= '0;
    in_ch.reg_b <= '0;
    in_ch.reg_c <= '0;
    in_ch.reg_d <= '0;
    in_ch.uid <= '0;
    in_ch.producer_class <= CLS_OTHER;
    in_ch.long_load <= 1'b0;
    in_ch.chain <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: duplicates, blocked reserve, chains, owner match, re-reserve, extremes.
    send(CMD_RESERVE, 6'd0, 8'd1, 8'd2, 8'd3, 8'd3, 32'h1, CLS_GLOBAL, 1'b1, 1'b0);
    send(CMD_RESERVE, 6'd0, 8'd2, 8'd4, 8'd0, 8'd0, 32'h2, CLS_ALU, 1'b0, 1'b0);
    send(CMD_CHECK, 6'd0, 8'd4, 8'd0, 8'd0, 8'd0, 32'h0, CLS_OTHER, 1'b0, 1'b0);
    send(CMD_CHECK, 6'd0, 8'd1, 8'd9, 8'd0, 8'd0, 32'h0, CLS_OTHER, 1'b0, 1'b1);
    send(CMD_CHECK, 6'd0, 8'd5, 8'd0, 8'd0, 8'd0, 32'h0, CLS_OTHER, 1'b0, 1'b1);
    send(CMD_CHECK, 6'd0, 8'd5, 8'd0, 8'd0, 8'd0, 32'h0, CLS_OTHER, 1'b0, 1'b0);
    send(CMD_QUERY, 6'd0, 8'd1, 8'd0, 8'd0, 8'd0, 32'h0, CLS_OTHER, 1'b0, 1'b0);
    send(CMD_READY, 6'd0, 8'd2, 8'd3, 8'd0, 8'd0, 32'h7, CLS_OTHER, 1'b0, 1'b0);
    send(CMD_READY, 6'd0, 8'd2, 8'd0, 8'd0, 8'd0, 32'h1, CLS_OTHER, 1'b0, 1'b0);
    send(CMD_CHECK, 6'd0, 8'd1, 8'd2, 8'd3, 8'd4, 32'h0, CLS_OTHER, 1'b0, 1'b0);
    send(CMD_RESERVE, 6'd0, 8'd2, 8'd0, 8'd0, 8'd0, 32'hFFFF_FFFF, 3'd7, 1'b0, 1'b0);
    send(CMD_CHECK, 6'd0, 8'd2, 8'd0, 8'd0, 8'd0, 32'h0, CLS_OTHER, 1'b0, 1'b0);
    send(CMD_QUERY, 6'd0, 8'd2, 8'd0, 8'd0, 8'd0, 32'h0, CLS_OTHER, 1'b0, 1'b0);
    send(CMD_RELEASE, 6'd0, 8'd1, 8'd2, 8'd3, 8'd0, 32'h2, CLS_OTHER, 1'b0, 1'b0);
    send(CMD_RELEASE, 6'd0, 8'd1, 8'd3, 8'd0, 8'd0, 32'h1, CLS_OTHER, 1'b0, 1'b0);
    send(CMD_RELEASE, 6'd0, 8'd2, 8'd0, 8'd0, 8'd0, 32'hFFFF_FFFF, CLS_OTHER, 1'b0, 1'b0);
    send(CMD_QUERY, 6'd0, 8'd1, 8'd0, 8'd0, 8'd0, 32'h0, CLS_OTHER, 1'b0, 1'b0);
    send(CMD_RESERVE, 6'd63, 8'd255, 8'd128, 8'd1, 8'd255, 32'h0, CLS_TMA, 1'b1, 1'b0);
    send(CMD_CHECK, 6'd63, 8'd255, 8'd128, 8'd0, 8'd0, 32'h0, CLS_OTHER, 1'b0, 1'b0);
    send(CMD_QUERY, 6'd63, 8'd0, 8'd0, 8'd0, 8'd0, 32'h0, CLS_OTHER, 1'b0, 1'b0);
    send(3'($urandom_range(7, 5)), 6'd63, 8'd255, 8'd255, 8'd255, 8'd255, 32'hFFFF_FFFF,
         3'd7, 1'b1, 1'b1);
    send(CMD_CHECK, 6'd1, 8'd3, 8'd0, 8'd0, 8'd0, 32'h0, CLS_OTHER, 1'b0, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1) ? 88 : (phase == 3) ? 20 : 0;
      recv_stall_pct = (phase == 2) ? 88 : (phase == 3) ? 20 : 0;
      for (int n = 0; n < 95; n++) begin
        if (phase == 0 && n == 30) hold_req = 1'b1;
        // Drain fully once, then resume.
        if (phase == 2 && n == 50) begin
          in_ch.valid <= 1'b0;
          @(posedge clk_i);
          @(posedge clk_i iff outstanding == 0);
        end
        send_random();
      end
    end
    in_ch.valid <= 1'b0;

    // Let the checker queue the last beat before waiting for the drain.
    @(posedge clk_i);
    @(posedge clk_i iff outstanding == 0);
    repeat (30) @(posedge clk_i);
    if (fails == 0 && outstanding == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire
